/* sv/mvr_pkg.sv */
// shared constants, opcodes and types of the multichannel voltmeter readout
// no dependencies; used by mvr_bcd_serial and multichannel_voltmeter_readout
`default_nettype none

package mvr_pkg;

  // channel count and pass length
  localparam int CHANNELS    = 8;
  localparam int RESULTS_CAP = 8;
  localparam int PASS_LEN    = (CHANNELS < RESULTS_CAP) ? CHANNELS : RESULTS_CAP;
  localparam int CH_W        = $clog2(CHANNELS);

  // field widths
  localparam int CODE_W  = 16;
  localparam int MV_W    = 14;
  localparam int DIGIT_W = 4;
  localparam int DIGITS  = 4;
  localparam int BCD_W   = DIGITS * DIGIT_W;
  localparam int STEP_W  = $clog2(MV_W);

  // event opcodes
  localparam logic [2:0] OP_SAMPLE    = 3'd0;
  localparam logic [2:0] OP_TICK      = 3'd1;
  localparam logic [2:0] OP_OUTER_CW  = 3'd2;
  localparam logic [2:0] OP_OUTER_CCW = 3'd3;
  localparam logic [2:0] OP_INNER_CW  = 3'd4;
  localparam logic [2:0] OP_INNER_CCW = 3'd5;
  localparam logic [2:0] OP_PUSH      = 3'd6;

  // decimal digits of one reading
  typedef struct packed {
    logic [DIGIT_W-1:0] thousands;
    logic [DIGIT_W-1:0] hundreds;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] units;
  } bcd_digits_t;

  // converter status
  typedef struct packed {
    logic busy;
    logic done;
  } bcd_status_t;

endpackage

`default_nettype wire

/* sv/multichannel_voltmeter_readout.sv */
// multichannel voltmeter readout: stored codes, auto/manual event machine, decimal readings
// path: a sample is stored when it is taken; a reading goes through the load step, the
// 14-step serial decimal converter, its done flag and the hold step into the output register
// flow: readings of an auto pass are converted one at a time; the next event is taken only
// once the last reading of the event is in the output register, later while the output stalls
// reset: synchronous active-low rst_n gives auto mode, channel 0 selected, all codes zero
// depends on mvr_pkg and mvr_bcd_serial
`default_nettype none

module multichannel_voltmeter_readout (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // sample_channel[2:0], sample_code[18:3], zero pad
  input  wire logic [2:0]  in_tuser,   // opcode[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // shown_channel[2:0], digit_thousands[6:3],
                                       // digit_hundreds[10:7], digit_tens[14:11],
                                       // digit_units[18:15], zero pad
  output logic             out_tlast   // last_of_run
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_CONV = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0]                    state_r, state_nxt;
  logic                          manual_r, manual_nxt;
  logic [mvr_pkg::CH_W-1:0]      sel_r, sel_nxt;
  logic [mvr_pkg::CH_W-1:0]      cur_r, cur_nxt;
  logic                          pass_r, pass_nxt;
  logic [mvr_pkg::CODE_W-1:0]    codes_r [mvr_pkg::CHANNELS];
  logic                          out_valid_r, out_valid_nxt;
  logic [23:0]                   out_data_r;
  logic                          out_last_r;

  logic                          in_xact;
  logic                          out_xact;
  logic                          load_out;
  logic                          reading_last;
  logic                          store_en;
  logic [mvr_pkg::CH_W-1:0]      store_idx;
  logic [2:0]                    op;
  logic [2:0]                    sample_channel;
  logic [mvr_pkg::CODE_W-1:0]    sample_code;
  logic [mvr_pkg::CODE_W-1:0]    cur_code;
  logic [mvr_pkg::MV_W-1:0]      mv;
  logic                          conv_start;
  mvr_pkg::bcd_status_t          conv_status;
  mvr_pkg::bcd_digits_t          conv_digits;

  // input fields
  assign op             = in_tuser;
  assign sample_channel = in_tdata[2:0];
  assign sample_code    = in_tdata[18:3];

  assign in_tready = (state_r == S_IDLE);
  assign in_xact   = in_tvalid && in_tready;
  assign out_xact  = out_valid_r && out_tready;

  // millivolts: floor(code*8192/65535) is code/8, plus one at full scale
  assign cur_code = codes_r[cur_r];
  assign mv = {1'b0, cur_code[mvr_pkg::CODE_W-1:3]} + mvr_pkg::MV_W'(&cur_code);

  assign conv_start = (state_r == S_LOAD);

  mvr_bcd_serial u_bcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (conv_start),
    .value  (mv),
    .status (conv_status),
    .digits (conv_digits)
  );

  assign load_out     = (state_r == S_HOLD) && (!out_valid_r || out_tready);
  assign reading_last = !pass_r || (cur_r == mvr_pkg::CH_W'(mvr_pkg::PASS_LEN - 1));

  // sample store decode
  assign store_en  = in_xact && (op == mvr_pkg::OP_SAMPLE) &&
                     (32'(sample_channel) < mvr_pkg::CHANNELS);
  assign store_idx = mvr_pkg::CH_W'(sample_channel);

  // event machine
  always_comb begin
    state_nxt  = state_r;
    manual_nxt = manual_r;
    sel_nxt    = sel_r;
    cur_nxt    = cur_r;
    pass_nxt   = pass_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xact) begin
          unique case (op) inside
            mvr_pkg::OP_TICK: begin
              state_nxt = S_LOAD;
              pass_nxt  = !manual_r;
              cur_nxt   = manual_r ? sel_r : '0;
              if (!manual_r) sel_nxt = '0;
            end
            mvr_pkg::OP_OUTER_CW, mvr_pkg::OP_OUTER_CCW: begin
              state_nxt  = S_LOAD;
              manual_nxt = !manual_r;
              pass_nxt   = manual_r;
              cur_nxt    = manual_r ? '0 : sel_r;
              if (manual_r) sel_nxt = '0;
            end
            mvr_pkg::OP_INNER_CW: begin
              if (manual_r) begin
                sel_nxt = (sel_r == mvr_pkg::CH_W'(mvr_pkg::CHANNELS - 1)) ? '0
                                                                          : sel_r + 1'b1;
              end else begin
                state_nxt = S_LOAD;
                pass_nxt  = 1'b1;
                cur_nxt   = '0;
                sel_nxt   = '0;
              end
            end
            mvr_pkg::OP_INNER_CCW: begin
              if (manual_r) begin
                sel_nxt = (sel_r == '0) ? mvr_pkg::CH_W'(mvr_pkg::CHANNELS - 1)
                                        : sel_r - 1'b1;
              end else begin
                state_nxt = S_LOAD;
                pass_nxt  = 1'b1;
                cur_nxt   = '0;
                sel_nxt   = '0;
              end
            end
            mvr_pkg::OP_PUSH: begin
              if (manual_r) begin
                state_nxt = S_LOAD;
                pass_nxt  = 1'b0;
                cur_nxt   = sel_r;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_LOAD: begin
        state_nxt = S_CONV;
      end
      S_CONV: begin
        if (conv_status.done) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (load_out) begin
          if (reading_last) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_LOAD;
            cur_nxt   = cur_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_xact) out_valid_nxt = 1'b0;
    if (load_out) out_valid_nxt = 1'b1;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      manual_r    <= 1'b0;
      sel_r       <= '0;
      cur_r       <= '0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      manual_r    <= manual_nxt;
      sel_r       <= sel_nxt;
      cur_r       <= cur_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // stored channel codes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mvr_pkg::CHANNELS; i++) begin
        codes_r[i] <= '0;
      end
    end else if (store_en) begin
      codes_r[store_idx] <= sample_code;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {5'd0, conv_digits.units, conv_digits.tens, conv_digits.hundreds,
                     conv_digits.thousands, 3'(cur_r)};
      out_last_r <= reading_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // converter is idle whenever a new event can be taken
  a_idle_conv: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !conv_status.busy)
    else $error("converter busy while taking events");

  // a load step always starts the converter
  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |=> conv_status.busy)
    else $error("converter did not start");

  // a stalled full output register holds the finished reading back
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOLD && out_valid_r && !out_tready) |=> (state_r == S_HOLD))
    else $error("reading dropped while output stalled");

  // the final reading of an auto pass leaves channel 0 selected
  a_pass_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && pass_r && reading_last) |-> (sel_r == '0))
    else $error("selected channel not cleared by auto pass");

endmodule

`default_nettype wire

/* sv/mvr_bcd_serial.sv */
// bit-serial binary to decimal converter (shift and add-3), one bit per cycle
// depends on mvr_pkg
`default_nettype none

module mvr_bcd_serial (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [mvr_pkg::MV_W-1:0]   value,
  output mvr_pkg::bcd_status_t            status,
  output mvr_pkg::bcd_digits_t            digits
);

  logic [mvr_pkg::MV_W-1:0]   bin_r, bin_nxt;
  logic [mvr_pkg::BCD_W-1:0]  bcd_r, bcd_nxt;
  logic [mvr_pkg::BCD_W-1:0]  adj;
  logic [mvr_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    adj = bcd_r;
    for (int d = 0; d < mvr_pkg::DIGITS; d++) begin
      if (bcd_r[d*mvr_pkg::DIGIT_W +: mvr_pkg::DIGIT_W] >= 4'd5) begin
        adj[d*mvr_pkg::DIGIT_W +: mvr_pkg::DIGIT_W] =
          bcd_r[d*mvr_pkg::DIGIT_W +: mvr_pkg::DIGIT_W] + 4'd3;
      end
    end
  end

  // step sequencing
  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt  = value;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bcd_nxt = {adj[mvr_pkg::BCD_W-2:0], bin_r[mvr_pkg::MV_W-1]};
      bin_nxt = {bin_r[mvr_pkg::MV_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == mvr_pkg::STEP_W'(mvr_pkg::MV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // data shift registers
  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign status.busy       = busy_r;
  assign status.done       = done_r;
  assign digits.thousands  = bcd_r[15:12];
  assign digits.hundreds   = bcd_r[11:8];
  assign digits.tens       = bcd_r[7:4];
  assign digits.units      = bcd_r[3:0];

endmodule

`default_nettype wire

/* bench/mvr_readout_checker.sv */
`timescale 1ns / 1ps
// checker for multichannel_voltmeter_readout: watches the event and reading streams,
// predicts the readings of every accepted event and compares them field by field
// depends on mvr_pkg
module mvr_readout_checker
  import mvr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [23:0] in_tdata,   // sample_channel[2:0], sample_code[18:3], zero pad
  input  wire logic [2:0]  in_tuser,   // opcode[2:0]
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [23:0] out_tdata,  // shown_channel[2:0], thousands[6:3], hundreds[10:7],
                                       // tens[14:11], units[18:15], zero pad
  input  wire logic        out_tlast,  // last_of_run
  output int               errors,
  output int               pending
);

  // one reading as it leaves the block
  typedef struct packed {
    logic [2:0]  channel;
    bcd_digits_t digits;
    logic        last;
  } reading_t;

  // predicted state of the readout
  logic              manual_mode;
  logic [CH_W-1:0]   sel_channel;
  logic [CODE_W-1:0] stored_codes [CHANNELS];
  reading_t          due_readings [$];
  reading_t          want;

  // millivolts of a stored code, split into decimal digits
  function automatic void queue_reading(int unsigned ch, logic last);
    int unsigned mv;
    reading_t r;
    mv = stored_codes[ch % CHANNELS];
    mv = (mv * 8192) / 65535;
    r.channel = 3'(ch);
    r.digits.thousands = 4'(mv / 1000);
    r.digits.hundreds  = 4'((mv % 1000) / 100);
    r.digits.tens      = 4'((mv % 100) / 10);
    r.digits.units     = 4'(mv % 10);
    r.last = last;
    due_readings.push_back(r);
  endfunction

  // auto pass over every channel, selection back to channel 0
  function automatic void queue_pass();
    for (int i = 0; i < PASS_LEN; i++) begin
      queue_reading(i, i == PASS_LEN - 1);
    end
    sel_channel = '0;
  endfunction

  // event machine
  function automatic void apply_event(logic [2:0] op, logic [2:0] ch, logic [15:0] code);
    case (op)
      OP_SAMPLE: begin
        if (ch < CHANNELS) stored_codes[ch] = code;
      end
      OP_TICK: begin
        if (manual_mode) queue_reading(sel_channel, 1'b1);
        else queue_pass();
      end
      OP_OUTER_CW, OP_OUTER_CCW: begin
        if (manual_mode) begin
          manual_mode = 1'b0;
          queue_pass();
        end else begin
          manual_mode = 1'b1;
          queue_reading(sel_channel, 1'b1);
        end
      end
      OP_INNER_CW: begin
        if (manual_mode) sel_channel = (sel_channel == CHANNELS - 1) ? '0 : sel_channel + 1'b1;
        else queue_pass();
      end
      OP_INNER_CCW: begin
        if (manual_mode) sel_channel = (sel_channel == 0) ? CH_W'(CHANNELS - 1) : sel_channel - 1'b1;
        else queue_pass();
      end
      OP_PUSH: begin
        if (manual_mode) queue_reading(sel_channel, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t checker: %s expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endfunction

  // events are predicted before readings are compared, so the queue order holds
  always @(posedge clk) begin
    if (!rst_n) begin
      manual_mode = 1'b0;
      sel_channel = '0;
      for (int i = 0; i < CHANNELS; i++) stored_codes[i] = '0;
      due_readings.delete();
      errors = 0;
    end else begin
      if (in_tvalid && in_tready) apply_event(in_tuser, in_tdata[2:0], in_tdata[18:3]);
      if (out_tvalid && out_tready) begin
        if (due_readings.size() == 0) begin
          errors++;
          $display("%0t checker: reading with none expected, got tdata %h last %b",
                   $time, out_tdata, out_tlast);
        end else begin
          want = due_readings.pop_front();
          check_field("channel", want.channel, out_tdata[2:0]);
          check_field("thousands", want.digits.thousands, out_tdata[6:3]);
          check_field("hundreds", want.digits.hundreds, out_tdata[10:7]);
          check_field("tens", want.digits.tens, out_tdata[14:11]);
          check_field("units", want.digits.units, out_tdata[18:15]);
          check_field("last", want.last, out_tlast);
        end
      end
    end
    pending = due_readings.size();
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// top of the multichannel_voltmeter_readout testbench: clock, reset, event stimulus,
// random reading backpressure and the verdict; depends on mvr_pkg and mvr_readout_checker
module tb;
  import mvr_pkg::*;

  localparam int          CLK_HALF  = 6;
  localparam int          MAX_CYCLE = 800000;
  localparam int          RAND_EVTS = 446;
  localparam logic [2:0]  OP_UNUSED = 3'd7;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [23:0] in_tdata   = '0;
  logic [2:0]  in_tuser   = OP_SAMPLE;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [23:0] out_tdata;
  logic        out_tlast;
  int          errors;
  int          pending;

  int          cycles     = 0;
  bit          send_quiet = 1'b0;
  bit          recv_quiet = 1'b0;
  int          recv_stall = 0;
  logic        out_taken  = 1'b0;

  always #(CLK_HALF) clk = ~clk;

  multichannel_voltmeter_readout u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  mvr_readout_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .errors     (errors),
    .pending    (pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // reading backpressure: a fresh stall after each transaction, with quiet stretches
  always @(posedge clk) out_taken <= out_tvalid && out_tready;

  always @(negedge clk) begin
    if (out_taken) begin
      if ($urandom_range(0, 15) == 0) recv_quiet = !recv_quiet;
      recv_stall = recv_quiet ? 0 : $urandom_range(0, 11);
    end
    if (recv_stall > 0) begin
      out_tready <= 1'b0;
      recv_stall--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // one event transaction after a random gap; valid stays high when there is no gap
  task automatic send_event(logic [2:0] op, logic [2:0] ch, logic [15:0] code);
    int gap;
    if ($urandom_range(0, 19) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'b0, code, ch};
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [2:0] pick_op();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return OP_SAMPLE;
    if (pick < 44) return OP_TICK;
    if (pick < 52) return OP_OUTER_CW;
    if (pick < 60) return OP_OUTER_CCW;
    if (pick < 72) return OP_INNER_CW;
    if (pick < 84) return OP_INNER_CCW;
    if (pick < 97) return OP_PUSH;
    return OP_UNUSED;
  endfunction

  function automatic logic [15:0] pick_code();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 15));
      3:       return 16'hFFFF - 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int counted;
    logic [2:0] op;
    counted = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // pass over codes still at reset
    send_event(OP_TICK, 3'd0, 16'h0000);
    // extremes and mid-scale codes
    send_event(OP_SAMPLE, 3'd0, 16'hFFFF);
    send_event(OP_SAMPLE, 3'd1, 16'h0001);
    send_event(OP_SAMPLE, 3'd2, 16'hFFFE);
    send_event(OP_SAMPLE, 3'd3, 16'h0008);
    send_event(OP_SAMPLE, 3'd4, 16'h8000);
    send_event(OP_SAMPLE, 3'd5, 16'h5555);
    send_event(OP_SAMPLE, 3'd6, 16'hAAAA);
    send_event(OP_SAMPLE, 3'd7, 16'h0000);
    send_event(OP_TICK, 3'd0, 16'h0000);
    // push in auto mode and the unused opcode do nothing
    send_event(OP_PUSH, 3'd0, 16'h0000);
    send_event(OP_UNUSED, 3'd7, 16'hFFFF);
    send_event(OP_INNER_CW, 3'd0, 16'h0000);
    send_event(OP_INNER_CCW, 3'd0, 16'h0000);
    // manual mode, selection wraps both ways
    send_event(OP_OUTER_CW, 3'd0, 16'h0000);
    send_event(OP_INNER_CCW, 3'd0, 16'h0000);
    send_event(OP_TICK, 3'd0, 16'h0000);
    send_event(OP_INNER_CW, 3'd0, 16'h0000);
    send_event(OP_INNER_CW, 3'd0, 16'h0000);
    send_event(OP_PUSH, 3'd0, 16'h0000);
    send_event(OP_UNUSED, 3'd0, 16'h0000);
    // back to auto, then manual again shows the selection reset by the pass
    send_event(OP_OUTER_CCW, 3'd0, 16'h0000);
    send_event(OP_OUTER_CCW, 3'd0, 16'h0000);
    send_event(OP_OUTER_CW, 3'd0, 16'h0000);

    // random events of every kind
    while (counted < RAND_EVTS) begin
      op = pick_op();
      send_event(op, 3'($urandom_range(0, 7)), pick_code());
      counted++;
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
